[rtl/abs_pkg.sv]
// shared types, codes and sizes for the alternating-bit sender
package abs_pkg;

   localparam int PAYLOAD_BYTES = 20;
   localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
   // signed byte sum spans -128*n .. 127*n
   localparam int SUM_W         = $clog2(PAYLOAD_BYTES * 128) + 1;
   localparam int WORD_W        = 32;
   localparam int LOW_W         = 64;
   localparam int MID_W         = 64;
   localparam int HIGH_W        = 32;
   localparam int REQ_DATA_W    = 256;
   localparam int RSP_DATA_W    = 200;

   typedef enum logic [1:0] {
      MODE_MSG   = 2'd0,
      MODE_ACK   = 2'd1,
      MODE_TIMER = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_SEND = 2'd1,
      ACT_STOP = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      DROP_NONE            = 3'd0,
      DROP_BUSY            = 3'd1,
      DROP_NOT_WAITING     = 3'd2,
      DROP_CORRUPTED       = 3'd3,
      DROP_WRONG_ACK       = 3'd4,
      DROP_NOTHING_PENDING = 3'd5
   } drop_type;

   // ack number carried by every data packet
   localparam logic signed [1:0] DATA_ACK = -2'sd1;

   typedef struct packed {
      mode_type                 mode;
      logic [PAYLOAD_W-1:0]     payload;
      logic [WORD_W-1:0]        seq;
      logic [WORD_W-1:0]        ack;
      logic [WORD_W-1:0]        checksum;
   } req_type;

   typedef struct packed {
      action_type               action;
      drop_type                 drop_reason;
      logic                     out_seq;
      logic signed [1:0]        out_ack;
      logic [WORD_W-1:0]        out_checksum;
      logic [PAYLOAD_W-1:0]     payload;
      logic                     busy;
   } rsp_type;

endpackage

[rtl/alternating_bit_sender_unit.sv]
// top level of the alternating-bit sender: request register, decision, response register
//
// Sender half of the alternating-bit protocol. Each request on the req_ channel is one
// event, selected by req_tuser: a message from the upper layer, an arriving ack packet,
// or a timer expiry. Every request yields exactly one response on the rsp_ channel;
// rsp_tuser carries the action (nothing, send packet and start timer, or stop timer),
// and rsp_tdata carries the drop reason, the packet sent and the busy flag.
// A request is held in the request register and decided, and its response is registered
// in the response register once that register can advance; rsp_tvalid then rises.
// One request per cycle while the receiver does not stall; the checksum adder tree and the protocol
// state update both sit between the request register and the response register.
// Reset clears both valid flags and the protocol state (idle, sequence bit zero); the
// held packet carries no reset and is only read once a message has been stored.
// When the receiver stalls, the response register holds and the request register
// still takes one more request; req_tready then drops until the response is taken.
module alternating_bit_sender_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // mode
   input  logic [1:0]                         req_tuser,
   // payload_low, payload_mid, payload_high, in_seq, in_ack, in_checksum
   input  logic [abs_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // action
   output logic [1:0]                         rsp_tuser,
   // drop_reason, out_seq, out_ack, out_checksum, out_payload_low, out_payload_mid,
   // out_payload_high, busy_res, one zero pad bit
   output logic [abs_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import abs_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   req_type              req_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff;
   logic                 advance;
   logic                 fire;
   logic                 take;
   req_type              req_unpacked;
   rsp_type              result;
   logic signed [SUM_W-1:0] byte_sum;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign req_unpacked.mode     = mode_type'(req_tuser);
   assign req_unpacked.payload  = req_tdata[PAYLOAD_W-1:0];
   assign req_unpacked.seq      = req_tdata[PAYLOAD_W +: WORD_W];
   assign req_unpacked.ack      = req_tdata[PAYLOAD_W+WORD_W +: WORD_W];
   assign req_unpacked.checksum = req_tdata[PAYLOAD_W+2*WORD_W +: WORD_W];

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_ff <= req_unpacked;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   abs_csum u_csum (
      .payload  (req_ff.payload),
      .byte_sum (byte_sum)
   );

   abs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .req      (req_ff),
      .byte_sum (byte_sum),
      .result   (result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.action;
   assign rsp_tdata  = {1'b0, rsp_ff.busy, rsp_ff.payload, rsp_ff.out_checksum,
                        rsp_ff.out_ack, rsp_ff.out_seq, rsp_ff.drop_reason};

endmodule

[rtl/abs_csum.sv]
// sum of the payload bytes, each taken as a signed byte
module abs_csum (
   input  logic [abs_pkg::PAYLOAD_W-1:0]    payload,
   output logic signed [abs_pkg::SUM_W-1:0] byte_sum
);
   import abs_pkg::*;

   always_comb begin
      logic signed [SUM_W-1:0] acc;
      acc = '0;
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         acc = acc + SUM_W'(signed'(payload[8*k +: 8]));
      end
      byte_sum = acc;
   end

endmodule

[rtl/abs_ctrl.sv]
// protocol state, held packet and per-request decision
module abs_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  abs_pkg::req_type                 req,
   input  logic signed [abs_pkg::SUM_W-1:0] byte_sum,
   output abs_pkg::rsp_type                 result
);
   import abs_pkg::*;

   logic                 waiting_ff, waiting_in;
   logic                 next_bit_ff, next_bit_in;
   logic                 expected_ff, expected_in;
   logic [PAYLOAD_W-1:0] held_payload_ff, held_payload_in;
   logic [WORD_W-1:0]    held_chk_ff, held_chk_in;

   logic [WORD_W-1:0]    sum_ext;
   logic [WORD_W-1:0]    chk_ack;
   logic [WORD_W-1:0]    chk_send;

   assign sum_ext  = {{(WORD_W-SUM_W){byte_sum[SUM_W-1]}}, byte_sum};
   assign chk_ack  = req.seq + req.ack + sum_ext;
   // seq bit plus ack of minus one
   assign chk_send = {{(WORD_W-1){1'b0}}, next_bit_ff} + {WORD_W{1'b1}} + sum_ext;

   always_comb begin
      waiting_in      = waiting_ff;
      next_bit_in     = next_bit_ff;
      expected_in     = expected_ff;
      held_payload_in = held_payload_ff;
      held_chk_in     = held_chk_ff;
      result          = '0;
      result.action      = ACT_NONE;
      result.drop_reason = DROP_NONE;

      case (req.mode)
         MODE_MSG: begin
            if (waiting_ff) begin
               result.drop_reason = DROP_BUSY;
            end else begin
               held_payload_in     = req.payload;
               expected_in         = next_bit_ff;
               held_chk_in         = chk_send;
               waiting_in          = 1'b1;
               next_bit_in         = ~next_bit_ff;
               result.action       = ACT_SEND;
               result.out_seq      = next_bit_ff;
               result.out_ack      = DATA_ACK;
               result.out_checksum = chk_send;
               result.payload      = req.payload;
            end
         end
         MODE_ACK: begin
            if (!waiting_ff) begin
               result.drop_reason = DROP_NOT_WAITING;
            end else if (chk_ack != req.checksum) begin
               result.drop_reason = DROP_CORRUPTED;
            end else if (req.ack != {{(WORD_W-1){1'b0}}, expected_ff}) begin
               result.drop_reason = DROP_WRONG_ACK;
            end else begin
               waiting_in    = 1'b0;
               result.action = ACT_STOP;
            end
         end
         MODE_TIMER: begin
            if (waiting_ff) begin
               result.action       = ACT_SEND;
               result.out_seq      = expected_ff;
               result.out_ack      = DATA_ACK;
               result.out_checksum = held_chk_ff;
               result.payload      = held_payload_ff;
            end else begin
               result.drop_reason = DROP_NOTHING_PENDING;
            end
         end
         default: begin
            result.action = ACT_NONE;
         end
      endcase

      result.busy = waiting_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff  <= 1'b0;
         next_bit_ff <= 1'b0;
         expected_ff <= 1'b0;
      end else if (fire) begin
         waiting_ff  <= waiting_in;
         next_bit_ff <= next_bit_in;
         expected_ff <= expected_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         held_payload_ff <= held_payload_in;
         held_chk_ff     <= held_chk_in;
      end
   end

   a_send_sets_waiting: assert property (@(posedge clock) disable iff (reset)
      fire && result.action == ACT_SEND |=> waiting_ff)
      else $error("send did not leave sender waiting");

   a_stop_clears_waiting: assert property (@(posedge clock) disable iff (reset)
      fire && result.action == ACT_STOP |=> !waiting_ff)
      else $error("accepted ack did not free sender");

   a_drop_keeps_state: assert property (@(posedge clock) disable iff (reset)
      fire && result.drop_reason != DROP_NONE |=>
         $stable(waiting_ff) && $stable(next_bit_ff) && $stable(expected_ff))
      else $error("dropped request changed protocol state");

   a_new_msg_flips_bit: assert property (@(posedge clock) disable iff (reset)
      fire && req.mode == MODE_MSG && !waiting_ff |=>
         next_bit_ff != $past(next_bit_ff) && expected_ff == $past(next_bit_ff))
      else $error("sequence bit not advanced on new message");

endmodule

[tb/alternating_bit_sender_unit_tb.sv]
// self-checking testbench for the alternating-bit sender unit
module alternating_bit_sender_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import abs_pkg::*;

   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam int         EVENT_TARGET   = 2000;
   localparam int         RESET_CYCLES   = 9;
   localparam int         IDLE_PERCENT   = 31;
   localparam int         HOLD_CYCLES    = 80;
   localparam int         HOLD_AT        = 300;
   localparam int         CALM_FROM      = 700;
   localparam int         CALM_TO        = 1000;
   localparam int         DRAIN_AT       = 1200;
   localparam int         WATCHDOG_LIMIT = 1000;
   localparam int         TAIL_CYCLES    = 4;
   localparam int         PRINT_LIMIT    = 40;

   typedef struct packed {
      logic [1:0]           mode;
      logic [PAYLOAD_W-1:0] payload;
      logic [WORD_W-1:0]    seq;
      logic [WORD_W-1:0]    ack;
      logic [WORD_W-1:0]    chk;
   } net_event_type;

   typedef struct packed {
      action_type           action;
      drop_type             drop;
      logic                 seq;
      logic [1:0]           ack;
      logic [WORD_W-1:0]    chk;
      logic [PAYLOAD_W-1:0] payload;
      logic                 busy;
   } sender_resp_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [1:0]             req_tuser  = '0;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [1:0]             rsp_tuser;
   logic [RSP_DATA_W-1:0]  rsp_tdata;

   alternating_bit_sender_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   net_event_type   event_queue[$];
   sender_resp_type expected_responses[$];

   int n_accepted  = 0;
   int n_responses = 0;
   int n_errors    = 0;
   int n_planned   = 0;
   int n_sent      = 0;
   int n_stopped   = 0;
   int drop_seen[6];

   // protocol state of the predictor
   logic                 st_waiting  = 1'b0;
   logic                 st_next     = 1'b0;
   logic                 st_expected = 1'b0;
   logic [PAYLOAD_W-1:0] held_payload;
   logic [WORD_W-1:0]    held_sum;

   // stimulus-side view of the protocol, used to build well-formed acks
   logic plan_waiting = 1'b0;
   logic plan_bit     = 1'b0;
   logic plan_next    = 1'b0;

   logic calm;
   assign calm = n_accepted >= CALM_FROM && n_accepted < CALM_TO;

   // seq + ack + every payload byte sign-extended, wrapping at 32 bits
   function automatic logic [WORD_W-1:0] packet_sum(logic [WORD_W-1:0] seq,
                                                    logic [WORD_W-1:0] ack,
                                                    logic [PAYLOAD_W-1:0] payload);
      logic [WORD_W-1:0] s;
      s = seq + ack;
      for (int k = 0; k < PAYLOAD_BYTES; k++)
         s = s + {{24{payload[8*k+7]}}, payload[8*k +: 8]};
      return s;
   endfunction

   function automatic sender_resp_type sender_reaction(net_event_type ev);
      sender_resp_type r;
      logic            send;
      r    = '0;
      send = 1'b0;
      case (ev.mode)
         MODE_MSG: begin
            if (st_waiting) begin
               r.drop = DROP_BUSY;
            end else begin
               held_payload = ev.payload;
               st_expected  = st_next;
               held_sum     = packet_sum({31'd0, st_expected}, 32'hFFFF_FFFF, ev.payload);
               st_waiting   = 1'b1;
               st_next      = ~st_next;
               send         = 1'b1;
            end
         end
         MODE_ACK: begin
            if (!st_waiting)
               r.drop = DROP_NOT_WAITING;
            else if (packet_sum(ev.seq, ev.ack, ev.payload) != ev.chk)
               r.drop = DROP_CORRUPTED;
            else if (ev.ack != {31'd0, st_expected})
               r.drop = DROP_WRONG_ACK;
            else begin
               st_waiting = 1'b0;
               r.action   = ACT_STOP;
            end
         end
         MODE_TIMER: begin
            if (st_waiting)
               send = 1'b1;
            else
               r.drop = DROP_NOTHING_PENDING;
         end
         default: ;
      endcase
      if (send) begin
         r.action  = ACT_SEND;
         r.seq     = st_expected;
         r.ack     = DATA_ACK;
         r.chk     = held_sum;
         r.payload = held_payload;
      end
      r.busy = st_waiting;
      return r;
   endfunction

   task automatic add_event(logic [1:0] mode, logic [PAYLOAD_W-1:0] p,
                            logic [WORD_W-1:0] s, logic [WORD_W-1:0] a,
                            logic [WORD_W-1:0] c);
      net_event_type ev;
      ev.mode    = mode;
      ev.payload = p;
      ev.seq     = s;
      ev.ack     = a;
      ev.chk     = c;
      event_queue.push_back(ev);
      if (mode != MODE_UNUSED)
         n_planned++;
      if (mode == MODE_MSG && !plan_waiting) begin
         plan_waiting = 1'b1;
         plan_bit     = plan_next;
         plan_next    = ~plan_next;
      end else if (mode == MODE_ACK && plan_waiting && a == {31'd0, plan_bit}
                   && c == packet_sum(s, a, p)) begin
         plan_waiting = 1'b0;
      end
   endtask

   function automatic logic [PAYLOAD_W-1:0] rand_payload();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return {PAYLOAD_BYTES{8'h80}};
         3:       return {PAYLOAD_BYTES{8'h7F}};
         default: return {$urandom, $urandom, $urandom, $urandom, $urandom};
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [PAYLOAD_W-1:0] want_v,
                                  logic [PAYLOAD_W-1:0] got_v);
      if (n_errors < PRINT_LIMIT)
         $display("response %0d: %s expected %0h got %0h", n_responses, what, want_v, got_v);
      n_errors++;
   endtask

   // request driver
   logic draining   = 1'b0;
   logic drain_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser  <= '0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_responses.push_back(sender_reaction(event_queue.pop_front()));
            n_accepted <= n_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            // one pause that lets every outstanding response come back
            if (!drain_done && n_accepted >= DRAIN_AT) begin
               draining   = 1'b1;
               drain_done = 1'b1;
            end
            if (draining && expected_responses.size() == 0)
               draining = 1'b0;
            if (event_queue.size() != 0 && !draining
                && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               req_tvalid <= 1'b1;
               req_tuser  <= event_queue[0].mode;
               req_tdata  <= {event_queue[0].chk, event_queue[0].ack,
                              event_queue[0].seq, event_queue[0].payload};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response side ready, with one long hold-off
   int   hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && n_accepted >= HOLD_AT) begin
         hold_left  <= HOLD_CYCLES;
         hold_done  <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(0, 99) >= IDLE_PERCENT;
      end
   end

   // response monitor
   sender_resp_type want, seen;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_responses <= n_responses + 1;
         if (expected_responses.size() == 0) begin
            report_mismatch("unexpected response", '0, rsp_tdata[PAYLOAD_W-1:0]);
         end else begin
            want         = expected_responses.pop_front();
            seen.action  = action_type'(rsp_tuser);
            seen.drop    = drop_type'(rsp_tdata[2:0]);
            seen.seq     = rsp_tdata[3];
            seen.ack     = rsp_tdata[5:4];
            seen.chk     = rsp_tdata[37:6];
            seen.payload = rsp_tdata[197:38];
            seen.busy    = rsp_tdata[198];
            if (seen.action !== want.action)
               report_mismatch("action", PAYLOAD_W'(want.action), PAYLOAD_W'(seen.action));
            if (seen.drop !== want.drop)
               report_mismatch("drop_reason", PAYLOAD_W'(want.drop), PAYLOAD_W'(seen.drop));
            if (seen.seq !== want.seq)
               report_mismatch("out_seq", PAYLOAD_W'(want.seq), PAYLOAD_W'(seen.seq));
            if (seen.ack !== want.ack)
               report_mismatch("out_ack", PAYLOAD_W'(want.ack), PAYLOAD_W'(seen.ack));
            if (seen.chk !== want.chk)
               report_mismatch("out_checksum", PAYLOAD_W'(want.chk), PAYLOAD_W'(seen.chk));
            if (seen.payload !== want.payload)
               report_mismatch("out_payload", want.payload, seen.payload);
            if (seen.busy !== want.busy)
               report_mismatch("busy_res", PAYLOAD_W'(want.busy), PAYLOAD_W'(seen.busy));
            if (want.action == ACT_SEND)
               n_sent++;
            if (want.action == ACT_STOP)
               n_stopped++;
            drop_seen[want.drop]++;
         end
      end
   end

   // no request or response moving for too long
   int stall_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("stalled with %0d requests queued and %0d responses outstanding",
                  event_queue.size(), expected_responses.size());
         $display("[alternating_bit_sender_unit] ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      logic [PAYLOAD_W-1:0] p;
      logic [WORD_W-1:0]    s, a, c;

      // corner cases first: idle drops, ignored mode, busy, resend, bad acks, wraps
      add_event(MODE_TIMER, '0, '0, '0, '0);
      add_event(MODE_ACK, '1, '1, '1, '1);
      add_event(MODE_UNUSED, '1, '1, '1, '1);
      add_event(MODE_MSG, '0, '1, '1, '1);
      add_event(MODE_MSG, '1, '0, '0, '0);
      add_event(MODE_TIMER, '1, '1, '1, '1);
      add_event(MODE_ACK, '0, '0, '0, 32'd1);
      add_event(MODE_ACK, '0, '0, 32'd1, 32'd1);
      // ack number compared over all 32 bits
      add_event(MODE_ACK, '0, '0, 32'h8000_0000, 32'h8000_0000);
      add_event(MODE_UNUSED, '0, '0, '0, '0);
      add_event(MODE_ACK, '0, '0, '0, '0);
      add_event(MODE_ACK, '0, '0, '0, '0);
      add_event(MODE_MSG, '1, '0, '0, '0);
      add_event(MODE_TIMER, '0, '0, '0, '0);
      add_event(MODE_ACK, '1, 32'h7FFF_FFFF, 32'd1, packet_sum(32'h7FFF_FFFF, 32'd1, '1));
      p = {PAYLOAD_BYTES{8'h80}};
      add_event(MODE_MSG, p, '0, '0, '0);
      add_event(MODE_ACK, p, 32'h8000_0000, '0, packet_sum(32'h8000_0000, '0, p));
      p = {PAYLOAD_BYTES{8'h7F}};
      add_event(MODE_MSG, p, '0, '0, '0);
      add_event(MODE_TIMER, '0, '0, '0, '0);
      add_event(MODE_ACK, '1, '1, 32'd1, packet_sum('1, 32'd1, '1));

      while (n_planned < EVENT_TARGET) begin
         p = rand_payload();
         s = $urandom;
         if ($urandom_range(0, 99) < 20) begin
            // noise: any mode, any fields, checksum right now and then
            a = $urandom;
            c = $urandom_range(0, 1) ? packet_sum(s, a, p) : $urandom;
            add_event(2'($urandom_range(0, 3)), p, s, a, c);
         end else if (plan_waiting) begin
            a = {31'd0, plan_bit};
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4, 5, 6, 7: add_event(MODE_ACK, p, s, a, packet_sum(s, a, p));
               8, 9, 10, 11:           add_event(MODE_TIMER, p, s, $urandom, $urandom);
               12, 13:                 add_event(MODE_MSG, p, s, $urandom, $urandom);
               14, 15: add_event(MODE_ACK, p, s, a,
                                 packet_sum(s, a, p) ^ (32'd1 << $urandom_range(0, 31)));
               16, 17: begin
                  a = {31'd0, ~plan_bit};
                  add_event(MODE_ACK, p, s, a, packet_sum(s, a, p));
               end
               18:     add_event(MODE_UNUSED, p, s, $urandom, $urandom);
               default: begin
                  // right low bit, stray upper bits
                  a = a | (32'd1 << $urandom_range(1, 31));
                  add_event(MODE_ACK, p, s, a, packet_sum(s, a, p));
               end
            endcase
         end else begin
            case ($urandom_range(0, 9))
               7: begin
                  a = $urandom_range(0, 1);
                  add_event(MODE_ACK, p, s, a, packet_sum(s, a, p));
               end
               8:       add_event(MODE_TIMER, p, s, $urandom, $urandom);
               9:       add_event(MODE_UNUSED, p, s, $urandom, $urandom);
               default: add_event(MODE_MSG, p, s, $urandom, $urandom);
            endcase
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (event_queue.size() != 0 || expected_responses.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d events checked: %0d packets sent or resent, %0d acks accepted",
               n_responses, n_sent, n_stopped);
      $display("drops: busy %0d, not waiting %0d, corrupted %0d, wrong ack %0d, idle timer %0d",
               drop_seen[DROP_BUSY], drop_seen[DROP_NOT_WAITING], drop_seen[DROP_CORRUPTED],
               drop_seen[DROP_WRONG_ACK], drop_seen[DROP_NOTHING_PENDING]);
      if (n_errors == 0)
         $display("[alternating_bit_sender_unit] OK");
      else
         $display("[alternating_bit_sender_unit] ERROR");
      $finish;
   end

endmodule
